/* hdl/hsv_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
package hsv_pkg;

    localparam int CHAN_W    = 8;
    localparam int OUT_W     = 15;
    localparam int NUM_W     = 23;     // widest dividend: 25600 * 255
    localparam int QUO_W     = 15;     // widest quotient: 25600
    localparam int HUE_W     = 16;     // hue sum before the wrap
    localparam int DIV_LANES = 2;

    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

    localparam int HUE_FULL  = 23040;  // 360 deg * 64
    localparam int HUE_SIXTY = 3840;   // 60 deg * 64
    localparam int PCT_FULL  = 25600;  // 100 % * 256
    localparam int CHAN_MAX  = 255;

    // brightness = floor(max * VAL_MUL / 2^VAL_SHIFT), exact for max 0..255;
    // VAL_MUL = 25600 * ceil(2^31 / 255)
    localparam longint unsigned VAL_MUL = 64'd215590528000;
    localparam int VAL_SHIFT  = 31;
    localparam int VAL_PROD_W = 46;    // 255 * VAL_MUL < 2^46

    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } hsv_sector_t;

    typedef struct packed {
        hsv_sector_t       sector;
        logic              black;
        logic [OUT_W-1:0]  val;
    } hsv_side_t;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [CHAN_W-1:0] den;
    } hsv_div_op_t;

    typedef hsv_div_op_t [DIV_LANES-1:0] hsv_div_ops_t;

    typedef logic [DIV_LANES-1:0][QUO_W-1:0] hsv_quo_t;

endpackage

/* hdl/hsv_front.sv */
// Front end: max/min search, hue sector choice, brightness and divider operand setup.
module hsv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hsv_pkg::CHAN_W-1:0]        in_red,
    input  logic [hsv_pkg::CHAN_W-1:0]        in_green,
    input  logic [hsv_pkg::CHAN_W-1:0]        in_blue,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hsv_pkg::hsv_div_ops_t             out_ops,
    output hsv_pkg::hsv_side_t                out_side
);

    // stage 1: channels plus max/min
    logic                       v1_reg, v1_next;
    logic [hsv_pkg::CHAN_W-1:0] r1_reg, g1_reg, b1_reg;
    logic [hsv_pkg::CHAN_W-1:0] mx1_reg, mx1_next, mn1_reg, mn1_next;
    logic                       rdy1, rdy2;

    // stage 2: divider operands
    logic                       v2_reg, v2_next;
    hsv_pkg::hsv_div_ops_t      ops2_reg, ops2_next;
    hsv_pkg::hsv_side_t         side2_reg, side2_next;

    logic [hsv_pkg::CHAN_W-1:0]     diff, opa, opb;
    logic [hsv_pkg::CHAN_W:0]       hue_off;
    logic [hsv_pkg::VAL_PROD_W-1:0] val_prod;

    assign rdy1     = !v1_reg || rdy2;
    assign rdy2     = !v2_reg || out_ready;
    assign in_ready = rdy1;

    always_comb begin
        mx1_next = in_red;
        mn1_next = in_red;
        if (in_green > mx1_next) mx1_next = in_green;
        if (in_blue  > mx1_next) mx1_next = in_blue;
        if (in_green < mn1_next) mn1_next = in_green;
        if (in_blue  < mn1_next) mn1_next = in_blue;
        v1_next = rdy1 ? in_valid : v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
        if (rdy1 && in_valid) begin
            r1_reg  <= in_red;
            g1_reg  <= in_green;
            b1_reg  <= in_blue;
            mx1_reg <= mx1_next;
            mn1_reg <= mn1_next;
        end
    end

    // red beats green beats blue on a tied max
    always_comb begin
        diff = mx1_reg - mn1_reg;
        priority if (diff == '0) begin
            side2_next.sector = hsv_pkg::SEC_GREY;
            opa = g1_reg;
            opb = b1_reg;
        end else if (mx1_reg == r1_reg) begin
            side2_next.sector = hsv_pkg::SEC_RED;
            opa = g1_reg;
            opb = b1_reg;
        end else if (mx1_reg == g1_reg) begin
            side2_next.sector = hsv_pkg::SEC_GREEN;
            opa = b1_reg;
            opb = r1_reg;
        end else begin
            side2_next.sector = hsv_pkg::SEC_BLUE;
            opa = r1_reg;
            opb = g1_reg;
        end
        side2_next.black = (mx1_reg == '0);

        // divide by 255 through a reciprocal multiply
        val_prod = hsv_pkg::VAL_PROD_W'(mx1_reg) * hsv_pkg::VAL_PROD_W'(hsv_pkg::VAL_MUL);
        side2_next.val = val_prod[hsv_pkg::VAL_SHIFT +: hsv_pkg::OUT_W];

        // a - b offset by diff, never negative
        hue_off = {1'b0, opa} + {1'b0, diff} - {1'b0, opb};

        ops2_next[hsv_pkg::LANE_HUE].num =
            hsv_pkg::NUM_W'(hue_off) * hsv_pkg::NUM_W'(hsv_pkg::HUE_SIXTY);
        ops2_next[hsv_pkg::LANE_HUE].den = diff;
        ops2_next[hsv_pkg::LANE_SAT].num =
            hsv_pkg::NUM_W'(diff) * hsv_pkg::NUM_W'(hsv_pkg::PCT_FULL);
        ops2_next[hsv_pkg::LANE_SAT].den = mx1_reg;

        v2_next = rdy2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
        if (rdy2 && v1_reg) begin
            ops2_reg  <= ops2_next;
            side2_reg <= side2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_ops   = ops2_reg;
    assign out_side  = side2_reg;

endmodule

/* hdl/hsv_div.sv */
// Pipelined restoring divider, hue and saturation lanes, one quotient bit per stage.
module hsv_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsv_pkg::hsv_div_ops_t in_ops,
    input  hsv_pkg::hsv_side_t    in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsv_pkg::hsv_quo_t     out_quo,
    output hsv_pkg::hsv_side_t    out_side
);

    localparam int NST = hsv_pkg::QUO_W;

    logic                  v_reg    [NST];
    hsv_pkg::hsv_div_ops_t part_reg [NST];   // num holds the running remainder
    hsv_pkg::hsv_quo_t     quo_reg  [NST];
    hsv_pkg::hsv_side_t    side_reg [NST];
    logic [NST:0]          rdy;

    assign rdy[NST] = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        localparam int BIT = NST - 1 - k;

        logic                  v_in, v_next;
        hsv_pkg::hsv_div_ops_t part_in, part_next;
        hsv_pkg::hsv_quo_t     quo_in, quo_next;
        hsv_pkg::hsv_side_t    side_in;
        logic [hsv_pkg::DIV_LANES-1:0][hsv_pkg::NUM_W-1:0] shifted;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign part_in = in_ops;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign part_in = part_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            part_next = part_in;
            quo_next  = quo_in;
            for (int l = 0; l < hsv_pkg::DIV_LANES; l++) begin
                shifted[l] = hsv_pkg::NUM_W'(part_in[l].den) << BIT;
                if (part_in[l].num >= shifted[l]) begin
                    part_next[l].num = part_in[l].num - shifted[l];
                    quo_next[l][BIT] = 1'b1;
                end
            end
            v_next = rdy[k] ? v_in : v_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else begin
                v_reg[k] <= v_next;
            end
            if (rdy[k] && v_in) begin
                part_reg[k] <= part_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_quo   = quo_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

/* hdl/rgb_to_hsv_converter.sv */
// RGB to HSV converter: top level with the hue finish stage and output register.
//
// Converts one 8-bit RGB pixel per transaction into hue (degrees*64, 0..23039),
// saturation and brightness (percent*256, 0..25600), all floored exactly. The
// block takes a new pixel every clock when nothing stalls and carries no state
// between pixels. A pixel passes through, in order, these registered stages:
// two front-end stages (max/min, then sector choice, operand setup and the
// brightness divide by 255 done as a reciprocal multiply), fifteen divider
// stages (one quotient bit per stage, hue and saturation lanes side by side,
// brightness riding along), and the output register where hue gets its sector
// offset and the wrap at 360 degrees. Every stage carries its own valid bit and
// only holds when the stage after it is full and stalled, so bubbles close up
// and s_ready stays high while any stage has room. Grey pixels give hue 0;
// black gives saturation 0; on a tied maximum red wins over green over blue.
module rgb_to_hsv_converter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hsv_pkg::CHAN_W-1:0]        s_red,
    input  logic [hsv_pkg::CHAN_W-1:0]        s_green,
    input  logic [hsv_pkg::CHAN_W-1:0]        s_blue,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hsv_pkg::OUT_W-1:0]         m_hue,
    output logic [hsv_pkg::OUT_W-1:0]         m_saturation,
    output logic [hsv_pkg::OUT_W-1:0]         m_brightness
);

    // front end to divider
    logic                  fe_valid, fe_ready;
    hsv_pkg::hsv_div_ops_t fe_ops;
    hsv_pkg::hsv_side_t    fe_side;

    // divider to output stage
    logic                  dv_valid, dv_ready;
    hsv_pkg::hsv_quo_t     dv_quo;
    hsv_pkg::hsv_side_t    dv_side;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [hsv_pkg::OUT_W-1:0]  hue_reg, hue_next;
    logic [hsv_pkg::OUT_W-1:0]  sat_reg, sat_next;
    logic [hsv_pkg::OUT_W-1:0]  val_reg, val_next;

    logic [hsv_pkg::HUE_W-1:0]  hue_base, hue_sum;

    hsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_red),
        .in_green  (s_green),
        .in_blue   (s_blue),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_ops   (fe_ops),
        .out_side  (fe_side)
    );

    hsv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_ops    (fe_ops),
        .in_side   (fe_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // output stage takes a transaction when empty or being drained
    assign dv_ready = !m_valid_reg || m_ready;

    always_comb begin
        unique case (dv_side.sector)
            hsv_pkg::SEC_RED:   hue_base = hsv_pkg::HUE_W'(hsv_pkg::HUE_FULL);
            hsv_pkg::SEC_GREEN: hue_base = hsv_pkg::HUE_W'(2 * hsv_pkg::HUE_SIXTY);
            hsv_pkg::SEC_BLUE:  hue_base = hsv_pkg::HUE_W'(4 * hsv_pkg::HUE_SIXTY);
            default:            hue_base = '0;
        endcase

        // quotient is 3840*(a-b)/diff offset by one sixty-degree step
        hue_sum = hue_base + hsv_pkg::HUE_W'(dv_quo[hsv_pkg::LANE_HUE])
                  - hsv_pkg::HUE_W'(hsv_pkg::HUE_SIXTY);
        if (hue_sum >= hsv_pkg::HUE_W'(hsv_pkg::HUE_FULL)) begin
            hue_sum = hue_sum - hsv_pkg::HUE_W'(hsv_pkg::HUE_FULL);
        end

        if (dv_side.sector == hsv_pkg::SEC_GREY) begin
            hue_next = '0;
        end else begin
            hue_next = hue_sum[hsv_pkg::OUT_W-1:0];
        end

        sat_next = dv_side.black ? '0 : dv_quo[hsv_pkg::LANE_SAT];
        val_next = dv_side.val;

        m_valid_next = dv_ready ? dv_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (dv_ready && dv_valid) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = val_reg;

    // hue always lands below 360 degrees after the wrap
    a_hue_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue < hsv_pkg::OUT_W'(hsv_pkg::HUE_FULL)))
        else $error("hue out of range");

    // saturation and brightness never exceed 100 percent
    a_pct_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_saturation <= hsv_pkg::OUT_W'(hsv_pkg::PCT_FULL)) &&
                    (m_brightness <= hsv_pkg::OUT_W'(hsv_pkg::PCT_FULL)))
        else $error("percent out of range");

    // input backpressure only when the whole pipe is full behind a stalled output
    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && fe_valid && dv_valid))
        else $error("input stalled with room in the pipeline");

endmodule
